>>> hdl/clsr_pkg.sv
// clsr_pkg: types, constants and the glyph table of the character display
// shadow refresh unit. No dependencies; imported by every module of the block except clsr_ram.

package clsr_pkg;

  // display geometry and timing
  localparam int unsigned MAX_COLS     = 32;
  localparam int unsigned CELLS        = 2 * MAX_COLS;
  localparam int unsigned ADDR_W       = $clog2(CELLS);
  localparam int unsigned COL_W        = $clog2(MAX_COLS);
  localparam int unsigned BLINK_PERIOD = 1024;
  localparam int unsigned BLINK_W      = $clog2(BLINK_PERIOD);

  localparam logic [7:0] SPACE    = 8'h20;
  localparam logic [7:0] CMD_ROW0 = 8'h80;
  localparam logic [7:0] CMD_ROW1 = 8'hC0;
  localparam logic [5:0] COLS_RESET = 6'd16;

  typedef enum logic [1:0] {
    OP_SET_CURSOR = 2'd0,
    OP_WRITE      = 2'd1,
    OP_CLEAR      = 2'd2,
    OP_TICK       = 2'd3
  } opcode_t;

  typedef struct packed {
    opcode_t    opcode;
    logic [7:0] char_code;
    logic [7:0] position;
    logic       blink;
  } in_item_t;

  typedef struct packed {
    logic [7:0] lcd_byte;
    logic       is_data;
    logic       last;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETC,
    ST_MOD,
    ST_WRITE,
    ST_CLEAR,
    ST_TIDX,
    ST_TCMD,
    ST_TDATA
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic latch_item;
    logic set_cursor;
    logic mod_step;
    logic write_cell;
    logic clear_all;
    logic tick_adv;
    logic load_cmd;
    logic load_data;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic mod_last;
    logic need_cmd;
    logic out_free;
  } dp_sts_t;

  // translation of codes 128..255
  localparam logic [7:0] GLYPH_ROM [128] = '{
    8'd200, 8'd201, 8'd202, 8'd203, 8'd215, 8'd216, 8'd217, 8'd218,
    8'd219, 8'd220, 8'd237, 8'd253, 8'd238, 8'd239, 8'd240, 8'd241,
    8'd242, 8'd244, 8'd204, 8'd205, 8'd206, 8'd207, 8'd208, 8'd209,
    8'd210, 8'd211, 8'd212, 8'd213, 8'd214, 8'd221, 8'd222, 8'd223,
    8'd231, 8'd232, 8'd233, 8'd234, 8'd235, 8'd236, 8'd243, 8'd245,
    8'd162, 8'd246, 8'd247, 8'd248, 8'd249, 8'd250, 8'd251, 8'd252,
    8'd254, 8'd255, 8'd32,  8'd32,  8'd32,  8'd32,  8'd32,  8'd32,
    8'd181, 8'd32,  8'd32,  8'd32,  8'd32,  8'd32,  8'd32,  8'd32,
    8'd65,  8'd160, 8'd66,  8'd161, 8'd224, 8'd69,  8'd163, 8'd164,
    8'd165, 8'd166, 8'd75,  8'd167, 8'd77,  8'd72,  8'd79,  8'd168,
    8'd80,  8'd67,  8'd84,  8'd169, 8'd170, 8'd88,  8'd225, 8'd171,
    8'd172, 8'd226, 8'd173, 8'd174, 8'd98,  8'd175, 8'd176, 8'd177,
    8'd97,  8'd178, 8'd179, 8'd180, 8'd227, 8'd101, 8'd182, 8'd183,
    8'd184, 8'd185, 8'd186, 8'd187, 8'd188, 8'd189, 8'd111, 8'd190,
    8'd112, 8'd99,  8'd191, 8'd121, 8'd228, 8'd120, 8'd229, 8'd192,
    8'd193, 8'd230, 8'd194, 8'd195, 8'd196, 8'd197, 8'd198, 8'd199
  };

endpackage

>>> hdl/char_lcd_shadow_refresh_unit.sv
// char_lcd_shadow_refresh_unit: two-row character display shadow with blink
// masks and cell-by-cell refresh. A write runs the radix-4 cursor modulo unit
// first; a tick advances the refresh index, then loads a data beat, after a
// row-start command beat where needed; output stalls hold those beats. One item in
// flight; the next is taken while the last beat sits in the output register.
// Reset is synchronous; the store reads as spaces at once through valid bits.

module char_lcd_shadow_refresh_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  clsr_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output clsr_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic [5:0]          cfg_wdata
);
  import clsr_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  clsr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_opcode(in_data.opcode),
    .sts      (sts),
    .cmd      (cmd)
  );

  clsr_datapath u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .sts      (sts),
    .in_data  (in_data),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  // an accepted item makes the block busy in the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken again right after an accept");

  // a command beat is never a final beat and is a row address
  a_cmd_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.is_data) |->
      (!out_data.last && (out_data.lcd_byte == CMD_ROW0 || out_data.lcd_byte == CMD_ROW1)))
    else $error("malformed command beat");

  // a pending command beat means the tick is unfinished
  a_cmd_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.is_data) |-> !in_ready)
    else $error("input open while a tick is mid-way");

  // a command beat is followed by data, never by another command
  a_cmd_then_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !out_data.is_data) |=> (!out_valid || out_data.is_data))
    else $error("two command beats in a row");

endmodule

>>> hdl/clsr_ram.sv
// clsr_ram: generic single-write, single-read RAM with registered read data.
// No dependencies; holds the character store of the refresh unit.

module clsr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> hdl/clsr_datapath.sv
// clsr_datapath: display shadow, blink masks, cursor, refresh counters,
// modulo unit and output register. Depends on clsr_pkg and clsr_ram.

module clsr_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  clsr_pkg::dp_cmd_t   cmd,
  output clsr_pkg::dp_sts_t   sts,
  input  clsr_pkg::in_item_t  in_data,
  input  logic                cfg_we,
  input  logic [5:0]          cfg_wdata,
  output logic                out_valid,
  input  logic                out_ready,
  output clsr_pkg::out_item_t out_data
);
  import clsr_pkg::*;

  logic [5:0]          columns_r;
  in_item_t            item_r;
  logic [7:0]          cursor_r, cursor_nxt;
  logic [ADDR_W-1:0]   refresh_idx_r;
  logic [BLINK_W-1:0]  blink_cnt_r, blink_cnt_nxt;
  logic [MAX_COLS-1:0] mask_r [2];
  logic [CELLS-1:0]    valid_r;
  logic [ADDR_W-1:0]   rem_r, rem_nxt;
  logic [7:0]          div_r;
  logic [1:0]          mod_cnt_r;
  logic [ADDR_W-1:0]   idx_r, idx_nxt;
  logic                cmd_row1_r;
  logic                out_valid_r;
  out_item_t           out_r;

  logic [5:0]          cols;
  logic [6:0]          cells;
  logic [6:0]          r1, r2;
  logic [ADDR_W-1:0]   r1_red;
  logic [ADDR_W:0]     idx_inc;
  logic                idx_wrap, idx_row1;
  logic                wr_row;
  logic [COL_W-1:0]    wr_col;
  logic                rd_row;
  logic [COL_W-1:0]    rd_col;
  logic [7:0]          ram_q, ch_raw, ch_rom, ch_out;
  logic                blank;
  logic                out_free;

  // effective column count, 0 acts as 1 and anything above the max as the max
  always_comb begin
    if (columns_r == 6'd0) begin
      cols = 6'd1;
    end else if (columns_r > 6'(MAX_COLS)) begin
      cols = 6'(MAX_COLS);
    end else begin
      cols = columns_r;
    end
  end
  assign cells = {cols, 1'b0};

  // cursor mod cells, two restoring steps per cycle
  always_comb begin
    r1     = {rem_r, div_r[7]};
    r1_red = (r1 >= cells) ? ADDR_W'(r1 - cells) : r1[ADDR_W-1:0];
    r2     = {r1_red, div_r[6]};
    rem_nxt = (r2 >= cells) ? ADDR_W'(r2 - cells) : r2[ADDR_W-1:0];
  end

  // row and column of the written cell
  assign wr_row     = (rem_r >= cols);
  assign wr_col     = wr_row ? COL_W'(rem_r - cols) : rem_r[COL_W-1:0];
  assign cursor_nxt = 8'({2'b00, rem_r} + 8'd1);

  // next refresh index and row-start commands
  assign idx_inc  = {1'b0, refresh_idx_r} + 7'd1;
  assign idx_wrap = (idx_inc >= cells);
  assign idx_nxt  = idx_wrap ? '0 : idx_inc[ADDR_W-1:0];
  assign idx_row1 = (idx_nxt == cols);
  assign blink_cnt_nxt = (blink_cnt_r == BLINK_W'(BLINK_PERIOD - 1)) ? '0
                                                                     : blink_cnt_r + 1'b1;

  // character for the refreshed cell
  assign rd_row = (idx_r >= cols);
  assign rd_col = rd_row ? COL_W'(idx_r - cols) : idx_r[COL_W-1:0];
  assign ch_raw = valid_r[idx_r] ? ram_q : SPACE;
  assign ch_rom = ch_raw[7] ? GLYPH_ROM[ch_raw[6:0]] : ch_raw;
  assign blank  = mask_r[rd_row][rd_col] && (blink_cnt_r < BLINK_W'(BLINK_PERIOD / 2));
  assign ch_out = blank ? SPACE : ch_rom;

  assign out_free = !out_valid_r || out_ready;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      columns_r <= COLS_RESET;
    end else if (cfg_we) begin
      columns_r <= cfg_wdata;
    end
  end

  // item latch and modulo unit
  always_ff @(posedge clk) begin
    if (cmd.latch_item) begin
      item_r <= in_data;
      rem_r  <= '0;
      div_r  <= cursor_r;
    end else if (cmd.mod_step) begin
      rem_r  <= rem_nxt;
      div_r  <= {div_r[5:0], 2'b00};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mod_cnt_r <= '0;
    end else if (cmd.latch_item) begin
      mod_cnt_r <= '0;
    end else if (cmd.mod_step) begin
      mod_cnt_r <= mod_cnt_r + 1'b1;
    end
  end

  // cursor, masks and valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_r  <= '0;
      mask_r[0] <= '0;
      mask_r[1] <= '0;
      valid_r   <= '0;
    end else if (cmd.clear_all) begin
      cursor_r  <= '0;
      mask_r[0] <= '0;
      mask_r[1] <= '0;
      valid_r   <= '0;
    end else if (cmd.set_cursor) begin
      cursor_r <= item_r.position;
    end else if (cmd.write_cell) begin
      cursor_r               <= cursor_nxt;
      mask_r[wr_row][wr_col] <= item_r.blink;
      valid_r[rem_r]         <= 1'b1;
    end
  end

  // refresh index and blink counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      refresh_idx_r <= '0;
      blink_cnt_r   <= '0;
    end else if (cmd.tick_adv) begin
      refresh_idx_r <= idx_nxt;
      blink_cnt_r   <= blink_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.tick_adv) begin
      idx_r      <= idx_nxt;
      cmd_row1_r <= idx_row1;
    end
  end

  // character store
  clsr_ram #(
    .WIDTH(8),
    .DEPTH(CELLS)
  ) u_store (
    .clk  (clk),
    .we   (cmd.write_cell),
    .waddr(rem_r),
    .wdata(item_r.char_code),
    .re   (cmd.tick_adv),
    .raddr(idx_nxt),
    .rdata(ram_q)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_cmd || cmd.load_data) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_cmd) begin
      out_r.lcd_byte <= cmd_row1_r ? CMD_ROW1 : CMD_ROW0;
      out_r.is_data  <= 1'b0;
      out_r.last     <= 1'b0;
    end else if (cmd.load_data) begin
      out_r.lcd_byte <= ch_out;
      out_r.is_data  <= 1'b1;
      out_r.last     <= 1'b1;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // status back to the controller
  assign sts.mod_last = (mod_cnt_r == 2'd3);
  assign sts.need_cmd = idx_wrap || idx_row1;
  assign sts.out_free = out_free;

endmodule

>>> hdl/clsr_ctrl.sv
// clsr_ctrl: sequencing state machine of the refresh unit, one item at a time.
// Depends on clsr_pkg; drives the command struct of clsr_datapath.

module clsr_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  clsr_pkg::opcode_t in_opcode,
  input  clsr_pkg::dp_sts_t sts,
  output clsr_pkg::dp_cmd_t cmd
);
  import clsr_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          unique case (in_opcode)
            OP_SET_CURSOR: state_nxt = ST_SETC;
            OP_WRITE:      state_nxt = ST_MOD;
            OP_CLEAR:      state_nxt = ST_CLEAR;
            OP_TICK:       state_nxt = ST_TIDX;
            default:       state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_SETC:  state_nxt = ST_IDLE;
      ST_MOD: begin
        if (sts.mod_last) begin
          state_nxt = ST_WRITE;
        end
      end
      ST_WRITE: state_nxt = ST_IDLE;
      ST_CLEAR: state_nxt = ST_IDLE;
      ST_TIDX:  state_nxt = sts.need_cmd ? ST_TCMD : ST_TDATA;
      ST_TCMD: begin
        if (sts.out_free) begin
          state_nxt = ST_TDATA;
        end
      end
      ST_TDATA: begin
        if (sts.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready       = 1'b1;
        cmd.latch_item = in_valid;
      end
      ST_SETC:  cmd.set_cursor = 1'b1;
      ST_MOD:   cmd.mod_step   = 1'b1;
      ST_WRITE: cmd.write_cell = 1'b1;
      ST_CLEAR: cmd.clear_all  = 1'b1;
      ST_TIDX:  cmd.tick_adv   = 1'b1;
      ST_TCMD:  cmd.load_cmd   = sts.out_free;
      ST_TDATA: cmd.load_data  = sts.out_free;
      default:  cmd = '0;
    endcase
  end

endmodule
